// ===== rtl/core/dps_pkg.sv =====
package dps_pkg;

  localparam int unsigned PwmW   = 16;
  localparam int unsigned MagW   = 15;
  localparam int unsigned FlagW  = 5;
  localparam int unsigned CfgIdxW = 2;

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] RegPwmLimit  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegPwmFloor  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegNoReverse = 2'd2;
  localparam logic [CfgIdxW-1:0] RegStepMax   = 2'd3;

  // Bit positions in the status flags
  localparam int unsigned FlagRevCut  = 0;
  localparam int unsigned FlagFloored = 1;
  localparam int unsigned FlagStepLim = 2;
  localparam int unsigned FlagPosBlk  = 3;
  localparam int unsigned FlagNegBlk  = 4;

  typedef struct packed {
    logic [MagW-1:0] mag_limit;
    logic [MagW-1:0] mag_floor;
    logic            no_reverse;
    logic [MagW-1:0] step_max;
  } dps_cfg_t;

  typedef struct packed {
    logic signed [PwmW-1:0] applied;
    logic signed [PwmW-1:0] desired;
    logic [FlagW-1:0]       flags;
  } dps_side_res_t;

endpackage

// ===== rtl/core/dps_ifs.sv =====
interface dps_req_if;
  logic                                valid;
  logic                                ready;
  logic signed [dps_pkg::PwmW-1:0]     left_request;
  logic signed [dps_pkg::PwmW-1:0]     right_request;
  logic                                estop;

  modport source (output valid, left_request, right_request, estop, input ready);
  modport sink   (input valid, left_request, right_request, estop, output ready);
endinterface

interface dps_res_if;
  logic                                valid;
  logic                                ready;
  logic signed [dps_pkg::PwmW-1:0]     left_applied;
  logic signed [dps_pkg::PwmW-1:0]     left_desired;
  logic [dps_pkg::FlagW-1:0]           left_flags;
  logic signed [dps_pkg::PwmW-1:0]     right_applied;
  logic signed [dps_pkg::PwmW-1:0]     right_desired;
  logic [dps_pkg::FlagW-1:0]           right_flags;

  modport source (output valid, left_applied, left_desired, left_flags,
                  right_applied, right_desired, right_flags, input ready);
  modport sink   (input valid, left_applied, left_desired, left_flags,
                  right_applied, right_desired, right_flags, output ready);
endinterface

// ===== rtl/core/dps_cfg_regs.sv =====
module dps_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [dps_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [dps_pkg::MagW-1:0]         cfg_wdata_i,
  output dps_pkg::dps_cfg_t                cfg_o
);

  dps_pkg::dps_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dps_pkg::RegPwmLimit:  cfg_d.mag_limit  = cfg_wdata_i;
        dps_pkg::RegPwmFloor:  cfg_d.mag_floor  = cfg_wdata_i;
        dps_pkg::RegNoReverse: cfg_d.no_reverse = cfg_wdata_i[0];
        dps_pkg::RegStepMax:   cfg_d.step_max   = cfg_wdata_i;
        default:               cfg_d            = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/dps_side.sv =====
module dps_side (
  input  dps_pkg::dps_cfg_t                cfg_i,
  input  logic signed [dps_pkg::PwmW-1:0]  prev_i,
  input  logic signed [dps_pkg::PwmW-1:0]  req_i,
  input  logic                             estop_i,
  output dps_pkg::dps_side_res_t           res_o
);

  localparam int unsigned W1 = dps_pkg::PwmW + 1;
  localparam int unsigned W2 = dps_pkg::PwmW + 2;

  logic signed [W1-1:0]     req_x, lim_s, flo_s, creq, dsr, tgt, app_x;
  logic [dps_pkg::MagW-1:0] flo_eff;
  logic signed [W2-1:0]     prev_x, delta, stp_s, app_w;
  logic [dps_pkg::FlagW-1:0] fl;

  always_comb begin
    req_x = {req_i[dps_pkg::PwmW-1], req_i};
    lim_s = $signed({2'b00, cfg_i.mag_limit});

    // clamp to +/- limit
    if (req_x > lim_s) begin
      creq = lim_s;
    end else if (req_x < -lim_s) begin
      creq = -lim_s;
    end else begin
      creq = req_x;
    end

    fl  = '0;
    dsr = creq;
    if (cfg_i.no_reverse && creq[W1-1]) begin
      dsr = '0;
      fl[dps_pkg::FlagRevCut] = 1'b1;
      fl[dps_pkg::FlagNegBlk] = 1'b1;
    end

    // floor never exceeds the limit
    flo_eff = (cfg_i.mag_floor > cfg_i.mag_limit) ? cfg_i.mag_limit : cfg_i.mag_floor;
    flo_s   = $signed({2'b00, flo_eff});
    tgt     = dsr;
    if (dsr > 0 && dsr < flo_s) begin
      tgt = flo_s;
    end else if (dsr < 0 && dsr > -flo_s) begin
      tgt = -flo_s;
    end
    if (tgt != dsr) begin
      fl[dps_pkg::FlagFloored] = 1'b1;
    end

    // slew toward the target; zero step holds
    prev_x = {{2{prev_i[dps_pkg::PwmW-1]}}, prev_i};
    stp_s  = $signed({3'b000, cfg_i.step_max});
    delta  = {tgt[W1-1], tgt} - prev_x;
    if (delta > stp_s) begin
      delta = stp_s;
    end else if (delta < -stp_s) begin
      delta = -stp_s;
    end
    app_w = prev_x + delta;
    app_x = app_w[W1-1:0];

    if (app_x != tgt) begin
      fl[dps_pkg::FlagStepLim] = 1'b1;
      if (tgt > app_x && creq > app_x) begin
        fl[dps_pkg::FlagPosBlk] = 1'b1;
      end
      if (tgt < app_x && creq < app_x) begin
        fl[dps_pkg::FlagNegBlk] = 1'b1;
      end
    end

    if (estop_i) begin
      res_o.applied = req_i;
      res_o.desired = req_i;
      res_o.flags   = '0;
    end else begin
      res_o.applied = app_x[dps_pkg::PwmW-1:0];
      res_o.desired = tgt[dps_pkg::PwmW-1:0];
      res_o.flags   = fl;
    end
  end

endmodule

// ===== rtl/core/drive_pwm_slew_shaper_core.sv =====
// Drive PWM slew shaper. Each transaction on in_req carries a signed PWM request per drive
// side plus an emergency-stop bit; each yields exactly one transaction on out_res with the
// applied value, the shaped target and five status flags per side. Shaping clamps to
// the magnitude limit, optionally cuts reverse, raises nonzero targets to the floor, then
// slews from the last applied value by at most step_max (zero holds it). With estop set the
// requests pass straight through and become the new applied values. Throughput is one item
// per cycle unless out_res stalls, set by the single shaping stage between the input
// register and the result register, which also updates the last-applied state. Write
// configuration only while no transaction is in flight.
module drive_pwm_slew_shaper_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dps_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [dps_pkg::MagW-1:0]      cfg_wdata_i,
  dps_req_if.sink                       in_req,
  dps_res_if.source                     out_res
);

  dps_pkg::dps_cfg_t      cfg;
  dps_pkg::dps_side_res_t left_res, right_res;

  logic                           s1_valid_q;
  logic signed [dps_pkg::PwmW-1:0] s1_lreq_q, s1_rreq_q;
  logic                           s1_estop_q;
  logic                           out_valid_q;
  dps_pkg::dps_side_res_t         out_left_q, out_right_q;
  logic signed [dps_pkg::PwmW-1:0] left_last_q, right_last_q;
  logic                           s1_adv, in_fire;

  dps_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  dps_side u_left (
    .cfg_i   (cfg),
    .prev_i  (left_last_q),
    .req_i   (s1_lreq_q),
    .estop_i (s1_estop_q),
    .res_o   (left_res)
  );

  dps_side u_right (
    .cfg_i   (cfg),
    .prev_i  (right_last_q),
    .req_i   (s1_rreq_q),
    .estop_i (s1_estop_q),
    .res_o   (right_res)
  );

  // advance when the result register is free or being drained
  assign s1_adv       = s1_valid_q && (!out_valid_q || out_res.ready);
  assign in_req.ready = !s1_valid_q || s1_adv;
  assign in_fire      = in_req.valid && in_req.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      left_last_q  <= '0;
      right_last_q <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q  <= 1'b1;
        left_last_q  <= left_res.applied;
        right_last_q <= right_res.applied;
      end else if (out_res.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_lreq_q  <= in_req.left_request;
      s1_rreq_q  <= in_req.right_request;
      s1_estop_q <= in_req.estop;
    end
    if (s1_adv) begin
      out_left_q  <= left_res;
      out_right_q <= right_res;
    end
  end

  assign out_res.valid         = out_valid_q;
  assign out_res.left_applied  = out_left_q.applied;
  assign out_res.left_desired  = out_left_q.desired;
  assign out_res.left_flags    = out_left_q.flags;
  assign out_res.right_applied = out_right_q.applied;
  assign out_res.right_desired = out_right_q.desired;
  assign out_res.right_flags   = out_right_q.flags;

endmodule

// ===== tb/dps_shaper_checker.sv =====
module dps_shaper_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dps_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [dps_pkg::MagW-1:0]      cfg_wdata_i,
  dps_req_if                            req,
  dps_res_if                            res,
  output int unsigned                   fail_count_o,
  output int unsigned                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CmpW = dps_pkg::PwmW;

  typedef struct packed {
    dps_pkg::dps_side_res_t lside;
    dps_pkg::dps_side_res_t rside;
  } pwm_pair_t;

  dps_pkg::dps_cfg_t cfg_shadow = '0;
  int          left_last  = 0;
  int          right_last = 0;
  int unsigned results_seen = 0;
  pwm_pair_t   expected_q[$];

  task automatic report(string msg);
    $display("%0t ns: result %0d: %s", $realtime, results_seen, msg);
    fail_count_o++;
  endtask

  task automatic check_field(string name, logic [CmpW-1:0] got, logic [CmpW-1:0] want);
    if (got !== want) begin
      report($sformatf("%s got %h expected %h", name, got, want));
    end
  endtask

  // Clamp, reverse cut, floor, then slew from the last applied value.
  function automatic void shape_side(input dps_pkg::dps_cfg_t c, input int prev,
                                     input int request,
                                     output dps_pkg::dps_side_res_t r,
                                     output int next_last);
    int lim, flo, stp, creq, tgt, shaped, delta, appl;
    logic [dps_pkg::FlagW-1:0] fl;
    lim = c.mag_limit;
    flo = c.mag_floor;
    stp = c.step_max;
    fl  = '0;
    creq = (request > lim) ? lim : ((request < -lim) ? -lim : request);
    tgt = creq;
    if (c.no_reverse && tgt < 0) begin
      tgt = 0;
      fl[dps_pkg::FlagRevCut] = 1'b1;
      fl[dps_pkg::FlagNegBlk] = 1'b1;
    end
    if (flo > lim) flo = lim;
    shaped = tgt;
    if (tgt > 0 && tgt < flo) shaped = flo;
    if (tgt < 0 && tgt > -flo) shaped = -flo;
    if (shaped != tgt) fl[dps_pkg::FlagFloored] = 1'b1;
    if (stp == 0) begin
      appl = prev;
    end else begin
      delta = shaped - prev;
      if (delta > stp) delta = stp;
      if (delta < -stp) delta = -stp;
      appl = prev + delta;
    end
    if (appl != shaped) begin
      fl[dps_pkg::FlagStepLim] = 1'b1;
      if (shaped > appl && creq > appl) fl[dps_pkg::FlagPosBlk] = 1'b1;
      if (shaped < appl && creq < appl) fl[dps_pkg::FlagNegBlk] = 1'b1;
    end
    r.applied = appl[CmpW-1:0];
    r.desired = shaped[CmpW-1:0];
    r.flags   = fl;
    next_last = appl;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pwm_pair_t want;
    if (!rst_ni) begin
      cfg_shadow = '0;
      left_last  = 0;
      right_last = 0;
      expected_q.delete();
      pending_o  = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          dps_pkg::RegPwmLimit:  cfg_shadow.mag_limit  = cfg_wdata_i;
          dps_pkg::RegPwmFloor:  cfg_shadow.mag_floor  = cfg_wdata_i;
          dps_pkg::RegNoReverse: cfg_shadow.no_reverse = cfg_wdata_i[0];
          dps_pkg::RegStepMax:   cfg_shadow.step_max   = cfg_wdata_i;
          default: ;
        endcase
      end

      if (req.valid && req.ready) begin
        if (req.estop) begin
          // pass through unshaped and store as the new applied values
          want.lside = '{applied: req.left_request, desired: req.left_request, flags: '0};
          want.rside = '{applied: req.right_request, desired: req.right_request, flags: '0};
          left_last  = req.left_request;
          right_last = req.right_request;
        end else begin
          shape_side(cfg_shadow, left_last, req.left_request, want.lside, left_last);
          shape_side(cfg_shadow, right_last, req.right_request, want.rside, right_last);
        end
        expected_q.push_back(want);
      end

      if (res.valid && res.ready) begin
        if (expected_q.size() == 0) begin
          report($sformatf("transaction with no pending request: left %h right %h",
                           res.left_applied, res.right_applied));
        end else begin
          want = expected_q.pop_front();
          check_field("left_applied", res.left_applied, want.lside.applied);
          check_field("left_desired", res.left_desired, want.lside.desired);
          check_field("left_flags", CmpW'(res.left_flags), CmpW'(want.lside.flags));
          check_field("right_applied", res.right_applied, want.rside.applied);
          check_field("right_desired", res.right_desired, want.rside.desired);
          check_field("right_flags", CmpW'(res.right_flags), CmpW'(want.rside.flags));
        end
        results_seen++;
      end
      pending_o = expected_q.size();
    end
  end

endmodule

// ===== tb/tb_drive_pwm_slew_shaper_core.sv =====
module tb_drive_pwm_slew_shaper_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit  = 400000;
  localparam int PhaseItems  = 215;
  localparam int NumPhases   = 8;
  localparam int LongHold    = 300;
  localparam int unsigned CfgW = dps_pkg::MagW;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_we;
  logic [dps_pkg::CfgIdxW-1:0] cfg_idx;
  logic [CfgW-1:0]             cfg_wdata;

  int unsigned fail_count;
  int unsigned pending;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          hold_requests = 0;
  int          cur_limit = 0;

  dps_req_if req_ch ();
  dps_res_if res_ch ();

  drive_pwm_slew_shaper_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_req      (req_ch),
    .out_res     (res_ch)
  );

  dps_shaper_checker shaper_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .req          (req_ch),
    .res          (res_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb_drive_pwm_slew_shaper_core: errors");
      $finish;
    end
  end

  // Result side: random stalls, plus a long hold-off on request.
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_pwm(int lreq, int rreq, bit stop);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid         <= 1'b1;
    req_ch.left_request  <= 16'(lreq);
    req_ch.right_request <= 16'(rreq);
    req_ch.estop         <= stop;
    do @(posedge clk_i); while (!req_ch.ready);
  endtask

  // Drop valid and wait until every pending transaction has come back.
  task automatic settle();
    req_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apply_cfg(int lim, int flo, bit norev, int stp);
    cfg_we    <= 1'b1;
    cfg_idx   <= dps_pkg::RegPwmLimit;
    cfg_wdata <= CfgW'(lim);
    @(posedge clk_i);
    cfg_idx   <= dps_pkg::RegPwmFloor;
    cfg_wdata <= CfgW'(flo);
    @(posedge clk_i);
    cfg_idx   <= dps_pkg::RegNoReverse;
    cfg_wdata <= CfgW'(norev);
    @(posedge clk_i);
    cfg_idx   <= dps_pkg::RegStepMax;
    cfg_wdata <= CfgW'(stp);
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    cur_limit = lim;
  endtask

  function automatic int pick_mag();
    case ($urandom_range(7))
      0:       return 0;
      1:       return 32767;
      2:       return 1;
      3:       return $urandom_range(64, 1);
      4:       return $urandom_range(2000, 100);
      default: return $urandom_range(32767);
    endcase
  endfunction

  function automatic int pick_request(int lim);
    int v;
    case ($urandom_range(9))
      0, 1, 2: v = $signed(16'($urandom));
      3, 4:    v = $urandom_range(128) - 64;
      5, 6:    v = (lim + $urandom_range(6) - 3) * ($urandom_range(1) ? 1 : -1);
      7: begin
        case ($urandom_range(3))
          0:       v = 32767;
          1:       v = -32767;
          2:       v = -32768;
          default: v = 0;
        endcase
      end
      default: v = $urandom_range(2 * lim) - lim;
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  initial begin
    int sent;
    int run_len;
    int lreq, rreq;
    req_ch.valid         = 1'b0;
    req_ch.left_request  = '0;
    req_ch.right_request = '0;
    req_ch.estop         = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = dps_pkg::RegPwmLimit;
    cfg_wdata = '0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: zero limit and zero step hold everything but estop requests
    send_pwm(100, -100, 0);
    send_pwm(-32768, 32767, 1);
    send_pwm(5, -5, 0);
    settle();
    apply_cfg(32767, 0, 0, 32767);
    send_pwm(32767, -32767, 0);
    send_pwm(-32768, 0, 0);
    send_pwm(0, -1, 0);
    send_pwm(-1, 1, 1);
    settle();
    // floor above limit, reverse blocked
    apply_cfg(1000, 2000, 1, 300);
    send_pwm(-500, 10, 0);
    send_pwm(1, -32768, 0);
    send_pwm(32767, 0, 0);
    send_pwm(999, 1000, 0);
    send_pwm(-1, 1001, 1);
    send_pwm(0, 0, 0);
    settle();
    apply_cfg(32767, 32767, 0, 0);
    send_pwm(1, -1, 0);
    send_pwm(-32768, 32767, 0);
    send_pwm(12345, -12345, 1);
    send_pwm(0, 0, 0);
    settle();
    apply_cfg(20000, 150, 0, 1);
    send_pwm(100, -100, 0);
    send_pwm(-20001, 20001, 0);
    send_pwm(0, 0, 0);
    send_pwm(-150, 150, 0);
    settle();

    for (int phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0:       apply_cfg(32767, 0, 0, 1);
        1:       apply_cfg(32767, 32767, 1, 32767);
        2:       apply_cfg(0, 0, 0, 32767);
        default: apply_cfg(pick_mag(), pick_mag(), $urandom_range(1), pick_mag());
      endcase
      case (phase % 4)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 52; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 52; end
        default: begin send_idle_pct = 16; stall_pct = 16; end
      endcase
      sent = 0;
      while (sent < PhaseItems) begin
        // hold a target for a run so the slew can reach it
        lreq = pick_request(cur_limit);
        rreq = pick_request(cur_limit);
        run_len = $urandom_range(12, 1);
        for (int k = 0; k < run_len && sent < PhaseItems; k++) begin
          if ($urandom_range(9) == 0) lreq = pick_request(cur_limit);
          if ($urandom_range(9) == 0) rreq = pick_request(cur_limit);
          send_pwm(lreq, rreq, $urandom_range(11) == 0);
          sent++;
          if ((phase == 0 || phase == 5) && sent == 60) hold_requests++;
        end
      end
      settle();
    end

    send_idle_pct = 0;
    stall_pct = 0;
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_drive_pwm_slew_shaper_core: clean");
    end else begin
      $display("tb_drive_pwm_slew_shaper_core: errors");
    end
    $finish;
  end

endmodule
